@@ rtl/tet_pkg.sv @@
// ----------------------------------------------------------------------------
// tet_pkg: shared types and constants for the timed event table
// Holds the command codes, the state type of the controller, the default
// sizes, the controller-to-datapath control record and the status record back.
// ----------------------------------------------------------------------------
package tet_pkg;

    localparam int TET_DEPTH     = 16;
    localparam int TET_ID_BITS   = 16;
    localparam int TET_TIME_BITS = 32;

    // Fixed widths of the stream fields.
    localparam int CMD_W   = 3;
    localparam int ID_W    = 16;
    localparam int TIME_W  = 32;
    localparam int COUNT_W = 5;
    localparam int IN_W    = 80;
    localparam int OUT_W   = 24;

    typedef enum logic [CMD_W-1:0] {
        CMD_ENQUEUE = 3'd0,
        CMD_CHANGE  = 3'd1,
        CMD_REMOVE  = 3'd2,
        CMD_TICK    = 3'd3,
        CMD_CLEAR   = 3'd4
    } cmd_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_EMIT,
        ST_WAIT,
        ST_RESP
    } state_t;

    typedef struct packed {
        logic capture;
        logic idx_clr;
        logic idx_inc;
        logic eval_en;
        logic commit;
        logic emit_load;
    } ctrl_t;

    typedef struct packed {
        logic [CMD_W-1:0] cmd;
        logic             idx_zero;
        logic             idx_end;
        logic             exp_any;
        logic             exp_one;
        logic             due_cur;
        logic             out_free;
    } stat_t;

endpackage

@@ rtl/tet_ram.sv @@
// ----------------------------------------------------------------------------
// tet_ram: generic single-clock RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module tet_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

@@ rtl/tet_ctrl.sv @@
// ----------------------------------------------------------------------------
// tet_ctrl: sequencing state machine of the timed event table
// Walks each request through the slot scan, the expiry emission or the
// final response as its command needs, and tells the datapath what to do in each cycle.
// ----------------------------------------------------------------------------
module tet_ctrl (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    input  logic [tet_pkg::CMD_W-1:0] in_cmd,
    output logic                    in_ready,
    input  tet_pkg::stat_t          stat,
    output tet_pkg::ctrl_t          ctrl
);

    tet_pkg::state_t state_reg;
    tet_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= tet_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            tet_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    if (in_cmd inside {tet_pkg::CMD_ENQUEUE, tet_pkg::CMD_CHANGE,
                                       tet_pkg::CMD_REMOVE, tet_pkg::CMD_TICK})
                    begin
                        state_next = tet_pkg::ST_SCAN;
                    end
                    else
                    begin
                        state_next = tet_pkg::ST_RESP;
                    end
                end
            end
            tet_pkg::ST_SCAN:
            begin
                if (stat.idx_end)
                begin
                    state_next = (stat.cmd == tet_pkg::CMD_TICK) ? tet_pkg::ST_EMIT
                                                                 : tet_pkg::ST_RESP;
                end
            end
            tet_pkg::ST_EMIT:
            begin
                if (!stat.exp_any)
                begin
                    state_next = tet_pkg::ST_RESP;
                end
                else if (stat.due_cur)
                begin
                    state_next = tet_pkg::ST_WAIT;
                end
            end
            tet_pkg::ST_WAIT:
            begin
                if (stat.out_free)
                begin
                    state_next = stat.exp_one ? tet_pkg::ST_IDLE : tet_pkg::ST_EMIT;
                end
            end
            tet_pkg::ST_RESP:
            begin
                if (stat.out_free)
                begin
                    state_next = tet_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = tet_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        ctrl     = '0;
        in_ready = 1'b0;
        case (state_reg)
            tet_pkg::ST_IDLE:
            begin
                in_ready     = 1'b1;
                ctrl.capture = in_valid;
                ctrl.idx_clr = in_valid;
            end
            tet_pkg::ST_SCAN:
            begin
                // The read issued for slot i returns in the next cycle, so the
                // evaluation trails the index by one.
                ctrl.idx_inc = 1'b1;
                ctrl.eval_en = !stat.idx_zero;
                ctrl.idx_clr = stat.idx_end;
            end
            tet_pkg::ST_EMIT:
            begin
                ctrl.idx_inc = stat.exp_any && !stat.due_cur;
            end
            tet_pkg::ST_WAIT:
            begin
                ctrl.emit_load = stat.out_free;
                ctrl.idx_inc   = stat.out_free;
            end
            tet_pkg::ST_RESP:
            begin
                ctrl.commit = stat.out_free;
            end
            default:
            begin
                ctrl = '0;
            end
        endcase
    end

endmodule

@@ rtl/tet_dp.sv @@
// ----------------------------------------------------------------------------
// tet_dp: datapath of the timed event table
// Slot stores, valid and due flags, the scan index, the lookup and expiry
// evaluation, the table updates and the result register.
// ----------------------------------------------------------------------------
module tet_dp #(
    parameter int TABLE_DEPTH = tet_pkg::TET_DEPTH,
    parameter int ID_BITS     = tet_pkg::TET_ID_BITS,
    parameter int TIME_BITS   = tet_pkg::TET_TIME_BITS
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic [tet_pkg::IN_W-1:0]    in_data,
    input  logic [tet_pkg::CMD_W-1:0]   in_cmd,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic [tet_pkg::OUT_W-1:0]   out_data,
    output logic                        out_last,
    input  tet_pkg::ctrl_t              ctrl,
    output tet_pkg::stat_t              stat
);

    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int CW = $clog2(TABLE_DEPTH + 1);

    // Request fields held for the duration of the request.
    logic [tet_pkg::CMD_W-1:0] cmd_reg;
    logic [ID_BITS-1:0]        id_reg;
    logic [TIME_BITS-1:0]      now_reg;
    logic [TIME_BITS-1:0]      dly_reg;

    logic [TABLE_DEPTH-1:0] valid_reg, valid_next;
    logic [TABLE_DEPTH-1:0] due_reg, due_next;
    logic [CW-1:0]          count_reg, count_next;
    logic [CW-1:0]          idx_reg, idx_next;
    logic [CW-1:0]          exp_reg, exp_next;
    logic                   found_reg, found_next;
    logic [AW-1:0]          match_reg, match_next;
    logic                   free_reg, free_next;
    logic [AW-1:0]          slot_reg, slot_next;

    logic                      oval_reg, oval_next;
    logic [tet_pkg::ID_W-1:0]  oid_reg, oid_next;
    logic                      oexp_reg, oexp_next;
    logic                      ofnd_reg, ofnd_next;
    logic                      oacc_reg, oacc_next;
    logic [tet_pkg::COUNT_W-1:0] ocnt_reg, ocnt_next;
    logic                      olast_reg, olast_next;

    logic [CW-1:0]        idx_prev;
    logic [AW-1:0]        eval_slot;
    logic [AW-1:0]        raddr;
    logic [AW-1:0]        waddr;
    logic [ID_BITS-1:0]   id_rdata;
    logic [TIME_BITS-1:0] start_rdata;
    logic [TIME_BITS-1:0] delay_rdata;
    logic [TIME_BITS:0]   due_sum;
    logic                 due_hit;
    logic                 match_hit;
    logic                 out_free;
    logic                 id_we, start_we, delay_we;
    logic                 is_enq, is_chg, is_rem;

    assign idx_prev  = idx_reg - CW'(1);
    assign eval_slot = idx_prev[AW-1:0];
    assign raddr     = (idx_reg == CW'(TABLE_DEPTH)) ? '0 : idx_reg[AW-1:0];
    assign waddr     = found_reg ? match_reg : slot_reg;
    assign out_free  = !oval_reg || out_ready;

    assign is_enq = (cmd_reg == tet_pkg::CMD_ENQUEUE);
    assign is_chg = (cmd_reg == tet_pkg::CMD_CHANGE);
    assign is_rem = (cmd_reg == tet_pkg::CMD_REMOVE);

    // An entry is due when start plus delay, taken one bit wider, does not
    // overflow the time width and lies below the present time.
    assign due_sum   = {1'b0, start_rdata} + {1'b0, delay_rdata};
    assign due_hit   = valid_reg[eval_slot] && !due_sum[TIME_BITS]
                       && (due_sum[TIME_BITS-1:0] < now_reg);
    assign match_hit = valid_reg[eval_slot] && (id_rdata == id_reg);

    assign id_we    = ctrl.commit && is_enq && !found_reg && free_reg;
    assign start_we = ctrl.commit && is_enq && (found_reg || free_reg);
    assign delay_we = start_we || (ctrl.commit && is_chg && found_reg);

    tet_ram #(.WIDTH(ID_BITS), .DEPTH(TABLE_DEPTH)) u_id_ram (
        .clk   (clk),
        .we    (id_we),
        .waddr (waddr),
        .wdata (id_reg),
        .raddr (raddr),
        .rdata (id_rdata)
    );

    tet_ram #(.WIDTH(TIME_BITS), .DEPTH(TABLE_DEPTH)) u_start_ram (
        .clk   (clk),
        .we    (start_we),
        .waddr (waddr),
        .wdata (now_reg),
        .raddr (raddr),
        .rdata (start_rdata)
    );

    tet_ram #(.WIDTH(TIME_BITS), .DEPTH(TABLE_DEPTH)) u_delay_ram (
        .clk   (clk),
        .we    (delay_we),
        .waddr (waddr),
        .wdata (dly_reg),
        .raddr (raddr),
        .rdata (delay_rdata)
    );

    always_comb
    begin
        valid_next = valid_reg;
        due_next   = due_reg;
        count_next = count_reg;
        idx_next   = idx_reg;
        exp_next   = exp_reg;
        found_next = found_reg;
        match_next = match_reg;
        free_next  = free_reg;
        slot_next  = slot_reg;
        oval_next  = oval_reg && !out_ready;
        oid_next   = oid_reg;
        oexp_next  = oexp_reg;
        ofnd_next  = ofnd_reg;
        oacc_next  = oacc_reg;
        ocnt_next  = ocnt_reg;
        olast_next = olast_reg;

        if (ctrl.capture)
        begin
            due_next   = '0;
            exp_next   = '0;
            found_next = 1'b0;
            free_next  = 1'b0;
        end

        if (ctrl.idx_clr)
        begin
            idx_next = '0;
        end
        else if (ctrl.idx_inc)
        begin
            idx_next = idx_reg + CW'(1);
        end

        if (ctrl.eval_en)
        begin
            if (cmd_reg == tet_pkg::CMD_TICK)
            begin
                if (due_hit)
                begin
                    valid_next[eval_slot] = 1'b0;
                    due_next[eval_slot]   = 1'b1;
                    exp_next              = exp_reg + CW'(1);
                    count_next            = count_reg - CW'(1);
                end
            end
            else
            begin
                if (match_hit && !found_reg)
                begin
                    found_next = 1'b1;
                    match_next = eval_slot;
                end
                if (!valid_reg[eval_slot] && !free_reg)
                begin
                    free_next = 1'b1;
                    slot_next = eval_slot;
                end
            end
        end

        if (ctrl.commit)
        begin
            case (cmd_reg)
                tet_pkg::CMD_ENQUEUE:
                begin
                    if (!found_reg && free_reg)
                    begin
                        valid_next[slot_reg] = 1'b1;
                        count_next           = count_reg + CW'(1);
                    end
                end
                tet_pkg::CMD_REMOVE:
                begin
                    if (found_reg)
                    begin
                        valid_next[match_reg] = 1'b0;
                        count_next            = count_reg - CW'(1);
                    end
                end
                tet_pkg::CMD_CLEAR:
                begin
                    valid_next = '0;
                    count_next = '0;
                end
                default:
                begin
                    count_next = count_reg;
                end
            endcase
            oval_next  = 1'b1;
            oid_next   = '0;
            oexp_next  = 1'b0;
            ofnd_next  = (is_enq || is_chg || is_rem) && found_reg;
            oacc_next  = !(is_enq && !found_reg && !free_reg);
            ocnt_next  = tet_pkg::COUNT_W'(count_next);
            olast_next = 1'b1;
        end

        if (ctrl.emit_load)
        begin
            oval_next  = 1'b1;
            oid_next   = tet_pkg::ID_W'(id_rdata);
            oexp_next  = 1'b1;
            ofnd_next  = 1'b0;
            oacc_next  = 1'b1;
            ocnt_next  = tet_pkg::COUNT_W'(count_reg);
            olast_next = (exp_reg == CW'(1));
            exp_next   = exp_reg - CW'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.capture)
        begin
            cmd_reg <= in_cmd;
            id_reg  <= ID_BITS'(in_data[tet_pkg::ID_W-1:0]);
            now_reg <= TIME_BITS'(in_data[tet_pkg::ID_W +: tet_pkg::TIME_W]);
            dly_reg <= TIME_BITS'(in_data[tet_pkg::ID_W + tet_pkg::TIME_W +: tet_pkg::TIME_W]);
        end
        oid_reg   <= oid_next;
        oexp_reg  <= oexp_next;
        ofnd_reg  <= ofnd_next;
        oacc_reg  <= oacc_next;
        ocnt_reg  <= ocnt_next;
        olast_reg <= olast_next;
        match_reg <= match_next;
        slot_reg  <= slot_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            due_reg   <= '0;
            count_reg <= '0;
            idx_reg   <= '0;
            exp_reg   <= '0;
            found_reg <= 1'b0;
            free_reg  <= 1'b0;
            oval_reg  <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
            due_reg   <= due_next;
            count_reg <= count_next;
            idx_reg   <= idx_next;
            exp_reg   <= exp_next;
            found_reg <= found_next;
            free_reg  <= free_next;
            oval_reg  <= oval_next;
        end
    end

    assign stat.cmd      = cmd_reg;
    assign stat.idx_zero = (idx_reg == '0);
    assign stat.idx_end  = (idx_reg == CW'(TABLE_DEPTH));
    assign stat.exp_any  = (exp_reg != '0);
    assign stat.exp_one  = (exp_reg == CW'(1));
    assign stat.due_cur  = due_reg[raddr];
    assign stat.out_free = out_free;

    assign out_valid = oval_reg;
    assign out_data  = {ocnt_reg, oacc_reg, ofnd_reg, oexp_reg, oid_reg};
    assign out_last  = olast_reg;

endmodule

@@ rtl/timed_event_table.sv @@
// ----------------------------------------------------------------------------
// timed_event_table: table of pending timed events with expiry on tick
//
//   channel | direction | handshake          | payload
//   s_*     | in        | s_tvalid/s_tready  | s_tuser command, s_tdata id/time/delay
//   m_*     | out       | m_tvalid/m_tready  | m_tdata result fields, m_tlast
//
// Enqueue, change and remove: the accepting cycle, a scan over all TABLE_DEPTH
// slots and the response. A tick scans alike, then revisits slots up to the
// last expired one and emits a result for each expired entry, or responds if
// none expired. Clear and unused codes go from acceptance to the response.
// Reset clears the valid flags and the count at once; no clearing pass.
// Low m_tready holds the result register and stalls only the step that writes
// it; a new request is taken while the last result waits.
// ----------------------------------------------------------------------------
module timed_event_table #(
    parameter int TABLE_DEPTH = tet_pkg::TET_DEPTH,
    parameter int ID_BITS     = tet_pkg::TET_ID_BITS,
    parameter int TIME_BITS   = tet_pkg::TET_TIME_BITS
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       s_tvalid,
    output logic                       s_tready,
    input  logic [tet_pkg::IN_W-1:0]   s_tdata,   // event_id, current_time, delay_ticks
    input  logic [tet_pkg::CMD_W-1:0]  s_tuser,   // command
    output logic                       m_tvalid,
    input  logic                       m_tready,
    output logic [tet_pkg::OUT_W-1:0]  m_tdata,   // event_id_out, expired, found,
                                                  // accepted, pending_count
    output logic                       m_tlast
);

    tet_pkg::ctrl_t ctrl;
    tet_pkg::stat_t stat;

    tet_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_cmd   (s_tuser),
        .in_ready (s_tready),
        .stat     (stat),
        .ctrl     (ctrl)
    );

    tet_dp #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .ID_BITS     (ID_BITS),
        .TIME_BITS   (TIME_BITS)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_data   (s_tdata),
        .in_cmd    (s_tuser),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (m_tdata),
        .out_last  (m_tlast),
        .ctrl      (ctrl),
        .stat      (stat)
    );

endmodule
